// File: src/dmr_pkg.sv
`timescale 1ns / 1ps
package dmr_pkg;

  // Field widths fixed by the item format
  localparam int unsigned DAY_W    = 22;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned NS_W     = 30;
  localparam int unsigned RDAY_W   = 23;
  localparam int unsigned TOTAL_W  = 63;

  // Seconds count of A: day * 86400 plus the rest fits 39 bits
  localparam int unsigned SECS_W   = 39;
  // Seconds that still fit a signed 64-bit nanosecond total
  localparam int unsigned MUL_W    = 34;
  localparam int unsigned SECS_LO_W = 17;
  localparam int unsigned PROD_W   = 47;
  localparam int unsigned SUM_W    = 64;

  localparam int unsigned NS_PER_S  = 1000000000;
  localparam int unsigned S_PER_MIN = 60;
  localparam int unsigned MIN_PER_H = 60;
  localparam int unsigned H_PER_DAY = 24;
  localparam int unsigned S_PER_DAY = 86400;
  localparam int unsigned S_PER_H   = 3600;
  localparam logic [SECS_W-1:0] SECS_MAX = 39'd9223372036;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_CMP,
    OP_CONV
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NEG,
    ST_INVALID,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_t;

  typedef struct packed {
    logic [DAY_W-1:0]  d;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    logic [MIN_W-1:0]  s;
    logic [NS_W-1:0]   ns;
  } span_t;

  typedef struct packed {
    op_t   op;
    span_t a;
    span_t b;
  } item_t;

  // Front stage: range checks, ordering, nanosecond digit, seconds count
  typedef struct packed {
    op_t               op;
    logic              canon_a;
    logic              canon_b;
    cmp_t              ord;
    logic              ns_carry;
    logic [NS_W-1:0]   r_ns;
    span_t             a;
    span_t             b;
    logic [SECS_W-1:0] secs;
  } s1_t;

  // Chain stage: digits resolved, status settled except product overflow
  typedef struct packed {
    status_t           status;
    cmp_t              cmp;
    logic [RDAY_W-1:0] r_d;
    logic [HOUR_W-1:0] r_h;
    logic [MIN_W-1:0]  r_m;
    logic [MIN_W-1:0]  r_s;
    logic [NS_W-1:0]   r_ns;
    logic              conv;
    logic [MUL_W-1:0]  secs;
    logic [NS_W-1:0]   a_ns;
  } s2_t;

  // Multiply stage: two partial products of seconds by 1e9
  typedef struct packed {
    status_t           status;
    cmp_t              cmp;
    logic [RDAY_W-1:0] r_d;
    logic [HOUR_W-1:0] r_h;
    logic [MIN_W-1:0]  r_m;
    logic [MIN_W-1:0]  r_s;
    logic [NS_W-1:0]   r_ns;
    logic              conv;
    logic [PROD_W-1:0] prod_lo;
    logic [PROD_W-1:0] prod_hi;
    logic [NS_W-1:0]   a_ns;
  } s3_t;

  typedef struct packed {
    status_t            status;
    cmp_t               cmp;
    logic [RDAY_W-1:0]  r_d;
    logic [HOUR_W-1:0]  r_h;
    logic [MIN_W-1:0]   r_m;
    logic [MIN_W-1:0]   r_s;
    logic [NS_W-1:0]    r_ns;
    logic [TOTAL_W-1:0] total;
  } res_t;

endpackage

// File: src/dmr_if.sv
`timescale 1ns / 1ps
interface dmr_in_if;
  import dmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [DAY_W-1:0]  a_day;
  logic [HOUR_W-1:0] a_hour;
  logic [MIN_W-1:0]  a_minute;
  logic [MIN_W-1:0]  a_second;
  logic [NS_W-1:0]   a_nanosecond;
  logic [DAY_W-1:0]  b_day;
  logic [HOUR_W-1:0] b_hour;
  logic [MIN_W-1:0]  b_minute;
  logic [MIN_W-1:0]  b_second;
  logic [NS_W-1:0]   b_nanosecond;

  modport source (
    output valid, operation, a_day, a_hour, a_minute, a_second, a_nanosecond,
    output b_day, b_hour, b_minute, b_second, b_nanosecond,
    input  ready
  );
  modport sink (
    input  valid, operation, a_day, a_hour, a_minute, a_second, a_nanosecond,
    input  b_day, b_hour, b_minute, b_second, b_nanosecond,
    output ready
  );
endinterface

interface dmr_out_if;
  import dmr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         compare_result;
  logic [RDAY_W-1:0]  r_day;
  logic [HOUR_W-1:0]  r_hour;
  logic [MIN_W-1:0]   r_minute;
  logic [MIN_W-1:0]   r_second;
  logic [NS_W-1:0]    r_nanosecond;
  logic [TOTAL_W-1:0] total_ns;

  modport source (
    output valid, status, compare_result, r_day, r_hour, r_minute, r_second,
    output r_nanosecond, total_ns,
    input  ready
  );
  modport sink (
    input  valid, status, compare_result, r_day, r_hour, r_minute, r_second,
    input  r_nanosecond, total_ns,
    output ready
  );
endinterface

// File: src/duration_mixed_radix_alu.sv
`timescale 1ns / 1ps
// Duration arithmetic on day/hour/minute/second/nanosecond operands.
// in_ch carries one operation with operands A and B per transfer; out_ch
// returns exactly one result per input transfer, in order.
// Operations: add, subtract, compare, and convert A to total nanoseconds.
// Pipeline of four register stages: range checks, ordering and the
// nanosecond digit; the second/minute/hour/day carry chain; the seconds
// by 1e9 partial products; the final sum and output register.
// One item can be accepted every cycle while out_ch.ready stays high.
// Each stage loads when it is empty or its successor moves, so bubbles
// close up and in_ch.ready only falls when all four stages are full and
// out_ch.ready is low. A stalled result holds steady on out_ch.
// Synchronous active-low reset empties every stage; no item is lost or
// repeated across a stall.
module duration_mixed_radix_alu (
  input  logic       clk,
  input  logic       rst_n,
  dmr_in_if.sink     in_ch,
  dmr_out_if.source  out_ch
);
  import dmr_pkg::*;

  item_t in_item;
  s1_t   s1;
  s2_t   s2;
  s3_t   s3;
  res_t  res;
  logic  v1;
  logic  v2;
  logic  v3;
  logic  v4;
  logic  en1;
  logic  en2;
  logic  en3;
  logic  en4;

  // Gather the input transfer
  always_comb begin
    in_item.op   = op_t'(in_ch.operation);
    in_item.a.d  = in_ch.a_day;
    in_item.a.h  = in_ch.a_hour;
    in_item.a.m  = in_ch.a_minute;
    in_item.a.s  = in_ch.a_second;
    in_item.a.ns = in_ch.a_nanosecond;
    in_item.b.d  = in_ch.b_day;
    in_item.b.h  = in_ch.b_hour;
    in_item.b.m  = in_ch.b_minute;
    in_item.b.s  = in_ch.b_second;
    in_item.b.ns = in_ch.b_nanosecond;
  end

  // Stage enables: load when empty or when the next stage moves
  assign en4 = !v4 || out_ch.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ch.ready = en1;

  dmr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en1),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .valid_r  (v1),
    .s1_r     (s1)
  );

  dmr_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en2),
    .in_valid (v1),
    .s1       (s1),
    .valid_r  (v2),
    .s2_r     (s2)
  );

  dmr_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en3),
    .in_valid (v2),
    .s2       (s2),
    .valid_r  (v3),
    .s3_r     (s3)
  );

  dmr_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en4),
    .in_valid (v3),
    .s3       (s3),
    .valid_r  (v4),
    .res_r    (res)
  );

  // Drive the result channel
  assign out_ch.valid          = v4;
  assign out_ch.status         = res.status;
  assign out_ch.compare_result = res.cmp;
  assign out_ch.r_day          = res.r_d;
  assign out_ch.r_hour         = res.r_h;
  assign out_ch.r_minute       = res.r_m;
  assign out_ch.r_second       = res.r_s;
  assign out_ch.r_nanosecond   = res.r_ns;
  assign out_ch.total_ns       = res.total;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1 && !en2 |=> v1)
    else $error("front stage item dropped during stall");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v4 && (res.status != ST_OK) |-> (res.r_d == '0) && (res.r_ns == '0) && (res.total == '0))
    else $error("error result carries non-zero payload");

  a_canon_out: assert property (@(posedge clk) disable iff (!rst_n)
    v4 |-> (res.r_h < HOUR_W'(H_PER_DAY)) && (res.r_m < MIN_W'(MIN_PER_H)) &&
           (res.r_s < MIN_W'(S_PER_MIN)) && (res.r_ns < NS_W'(NS_PER_S)))
    else $error("non-canonical add or subtract result");

  a_total_alone: assert property (@(posedge clk) disable iff (!rst_n)
    v4 && (res.total != '0) |-> (res.status == ST_OK) && (res.cmp == CMP_LT) &&
                                (res.r_d == '0) && (res.r_s == '0))
    else $error("total with other result fields set");
`endif
endmodule

// File: src/dmr_front.sv
`timescale 1ns / 1ps
module dmr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  dmr_pkg::item_t in_item,
  output logic          valid_r,
  output dmr_pkg::s1_t  s1_r
);
  import dmr_pkg::*;

  s1_t s1_nxt;
  logic [NS_W:0] ns_sum;
  logic [NS_W:0] ns_diff;

  // Check ranges, order the operands, resolve the nanosecond digit
  always_comb begin
    s1_nxt = '0;
    s1_nxt.op = in_item.op;
    s1_nxt.a  = in_item.a;
    s1_nxt.b  = in_item.b;
    s1_nxt.canon_a = (in_item.a.h < HOUR_W'(H_PER_DAY)) && (in_item.a.m < MIN_W'(MIN_PER_H)) &&
                     (in_item.a.s < MIN_W'(S_PER_MIN)) && (in_item.a.ns < NS_W'(NS_PER_S));
    s1_nxt.canon_b = (in_item.b.h < HOUR_W'(H_PER_DAY)) && (in_item.b.m < MIN_W'(MIN_PER_H)) &&
                     (in_item.b.s < MIN_W'(S_PER_MIN)) && (in_item.b.ns < NS_W'(NS_PER_S));

    // Most significant field first
    if (in_item.a.d != in_item.b.d) begin
      s1_nxt.ord = (in_item.a.d < in_item.b.d) ? CMP_LT : CMP_GT;
    end else if (in_item.a.h != in_item.b.h) begin
      s1_nxt.ord = (in_item.a.h < in_item.b.h) ? CMP_LT : CMP_GT;
    end else if (in_item.a.m != in_item.b.m) begin
      s1_nxt.ord = (in_item.a.m < in_item.b.m) ? CMP_LT : CMP_GT;
    end else if (in_item.a.s != in_item.b.s) begin
      s1_nxt.ord = (in_item.a.s < in_item.b.s) ? CMP_LT : CMP_GT;
    end else if (in_item.a.ns != in_item.b.ns) begin
      s1_nxt.ord = (in_item.a.ns < in_item.b.ns) ? CMP_LT : CMP_GT;
    end else begin
      s1_nxt.ord = CMP_EQ;
    end

    ns_sum  = {1'b0, in_item.a.ns} + {1'b0, in_item.b.ns};
    ns_diff = {1'b0, in_item.a.ns} - {1'b0, in_item.b.ns};
    if (in_item.op == OP_SUB) begin
      s1_nxt.ns_carry = ns_diff[NS_W];
      s1_nxt.r_ns = ns_diff[NS_W] ? NS_W'(ns_diff + (NS_W+1)'(NS_PER_S)) : ns_diff[NS_W-1:0];
    end else begin
      s1_nxt.ns_carry = (ns_sum >= (NS_W+1)'(NS_PER_S));
      s1_nxt.r_ns = s1_nxt.ns_carry ? NS_W'(ns_sum - (NS_W+1)'(NS_PER_S)) : ns_sum[NS_W-1:0];
    end

    // Seconds count of A for the convert path
    s1_nxt.secs = SECS_W'(in_item.a.d) * SECS_W'(S_PER_DAY) +
                  SECS_W'(in_item.a.h) * SECS_W'(S_PER_H) +
                  SECS_W'(in_item.a.m) * SECS_W'(S_PER_MIN) +
                  SECS_W'(in_item.a.s);
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      s1_r <= s1_nxt;
    end
  end
endmodule

// File: src/dmr_chain.sv
`timescale 1ns / 1ps
module dmr_chain (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  dmr_pkg::s1_t s1,
  output logic         valid_r,
  output dmr_pkg::s2_t s2_r
);
  import dmr_pkg::*;

  localparam int unsigned DG_W = 7;

  // One digit of the add chain: {carry, digit}
  function automatic logic [DG_W:0] digit_add(logic [DG_W-1:0] a, logic [DG_W-1:0] b,
                                              logic cin, logic [DG_W-1:0] radix);
    logic [DG_W-1:0] s;
    logic            c;
    s = a + b + DG_W'(cin);
    c = (s >= radix);
    if (c) s = s - radix;
    return {c, s};
  endfunction

  // One digit of the borrow chain: {borrow, digit}
  function automatic logic [DG_W:0] digit_sub(logic [DG_W-1:0] a, logic [DG_W-1:0] b,
                                              logic bin, logic [DG_W-1:0] radix);
    logic [DG_W-1:0] x;
    logic [DG_W-1:0] s;
    logic            br;
    x  = b + DG_W'(bin);
    br = (a < x);
    s  = a + (br ? radix : DG_W'(0)) - x;
    return {br, s};
  endfunction

  s2_t s2_nxt;
  logic [DG_W:0] dg_s;
  logic [DG_W:0] dg_m;
  logic [DG_W:0] dg_h;
  logic [RDAY_W-1:0] day_res;

  // Run the carry or borrow chain and settle status
  always_comb begin
    if (s1.op == OP_SUB) begin
      dg_s = digit_sub(DG_W'(s1.a.s), DG_W'(s1.b.s), s1.ns_carry, DG_W'(S_PER_MIN));
      dg_m = digit_sub(DG_W'(s1.a.m), DG_W'(s1.b.m), dg_s[DG_W], DG_W'(MIN_PER_H));
      dg_h = digit_sub(DG_W'(s1.a.h), DG_W'(s1.b.h), dg_m[DG_W], DG_W'(H_PER_DAY));
      day_res = RDAY_W'(s1.a.d) - (RDAY_W'(s1.b.d) + RDAY_W'(dg_h[DG_W]));
    end else begin
      dg_s = digit_add(DG_W'(s1.a.s), DG_W'(s1.b.s), s1.ns_carry, DG_W'(S_PER_MIN));
      dg_m = digit_add(DG_W'(s1.a.m), DG_W'(s1.b.m), dg_s[DG_W], DG_W'(MIN_PER_H));
      dg_h = digit_add(DG_W'(s1.a.h), DG_W'(s1.b.h), dg_m[DG_W], DG_W'(H_PER_DAY));
      day_res = RDAY_W'(s1.a.d) + RDAY_W'(s1.b.d) + RDAY_W'(dg_h[DG_W]);
    end

    s2_nxt = '0;
    s2_nxt.status = ST_OK;
    s2_nxt.cmp    = CMP_LT;
    s2_nxt.secs   = s1.secs[MUL_W-1:0];
    s2_nxt.a_ns   = s1.a.ns;
    case (s1.op)
      OP_ADD, OP_SUB: begin
        if (!(s1.canon_a && s1.canon_b)) begin
          s2_nxt.status = ST_INVALID;
        end else if (s1.op == OP_SUB && s1.ord == CMP_LT) begin
          s2_nxt.status = ST_NEG;
        end else begin
          s2_nxt.r_d  = day_res;
          s2_nxt.r_h  = dg_h[HOUR_W-1:0];
          s2_nxt.r_m  = dg_m[MIN_W-1:0];
          s2_nxt.r_s  = dg_s[MIN_W-1:0];
          s2_nxt.r_ns = s1.r_ns;
        end
      end
      OP_CMP: begin
        s2_nxt.cmp = s1.ord;
      end
      default: begin
        if (!s1.canon_a) begin
          s2_nxt.status = ST_INVALID;
        end else if (s1.secs > SECS_MAX) begin
          s2_nxt.status = ST_OVERFLOW;
        end else begin
          s2_nxt.conv = 1'b1;
        end
      end
    endcase
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      s2_r <= s2_nxt;
    end
  end
endmodule

// File: src/dmr_mul.sv
`timescale 1ns / 1ps
module dmr_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  dmr_pkg::s2_t s2,
  output logic         valid_r,
  output dmr_pkg::s3_t s3_r
);
  import dmr_pkg::*;

  s3_t s3_nxt;

  // Split the seconds count and scale each half by 1e9
  always_comb begin
    s3_nxt.status  = s2.status;
    s3_nxt.cmp     = s2.cmp;
    s3_nxt.r_d     = s2.r_d;
    s3_nxt.r_h     = s2.r_h;
    s3_nxt.r_m     = s2.r_m;
    s3_nxt.r_s     = s2.r_s;
    s3_nxt.r_ns    = s2.r_ns;
    s3_nxt.conv    = s2.conv;
    s3_nxt.a_ns    = s2.a_ns;
    s3_nxt.prod_lo = PROD_W'(s2.secs[SECS_LO_W-1:0]) * PROD_W'(NS_PER_S);
    s3_nxt.prod_hi = PROD_W'(s2.secs[MUL_W-1:SECS_LO_W]) * PROD_W'(NS_PER_S);
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      s3_r <= s3_nxt;
    end
  end
endmodule

// File: src/dmr_pack.sv
`timescale 1ns / 1ps
module dmr_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  dmr_pkg::s3_t  s3,
  output logic          valid_r,
  output dmr_pkg::res_t res_r
);
  import dmr_pkg::*;

  res_t res_nxt;
  logic [SUM_W-1:0] total;

  // Join the partial products, add nanoseconds, check the signed limit
  always_comb begin
    total = (SUM_W'(s3.prod_hi) << SECS_LO_W) + SUM_W'(s3.prod_lo) + SUM_W'(s3.a_ns);
    res_nxt.status = s3.status;
    res_nxt.cmp    = s3.cmp;
    res_nxt.r_d    = s3.r_d;
    res_nxt.r_h    = s3.r_h;
    res_nxt.r_m    = s3.r_m;
    res_nxt.r_s    = s3.r_s;
    res_nxt.r_ns   = s3.r_ns;
    res_nxt.total  = '0;
    if (s3.conv) begin
      if (total[SUM_W-1]) begin
        res_nxt.status = ST_OVERFLOW;
      end else begin
        res_nxt.total = total[TOTAL_W-1:0];
      end
    end
  end

  // Hold the result until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      res_r <= res_nxt;
    end
  end
endmodule
